// File: src/lkvt_pkg.sv
// Shared types and constants for the linear key-value table.
package lkvt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int CNT_OUT_W = 5;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_e;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [VAL_W-1:0]     value_out;
    logic                 status;
    logic [CNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic search;
    logic del_read;
    logic del_write;
    logic finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic search_done;
    logic del_hit;
  } sts_t;

endpackage

// File: src/lkvt_ctrl.sv
// Sequencing state machine of the linear key-value table.
module lkvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lkvt_pkg::sts_t sts_i,
  output lkvt_pkg::cmd_t cmd_o
);
  import lkvt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_FINISH = 5'b00100,
    S_DEL_RD = 5'b01000,
    S_DEL_WR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done) begin
          state_d = sts_i.del_hit ? S_DEL_RD : S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_DEL_RD: begin
        cmd_o.del_read = 1'b1;
        state_d        = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd_o.del_write = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: src/lkvt_datapath.sv
// Entry storage, scan pointer, count and result register of the key-value table.
module lkvt_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lkvt_pkg::req_t req_i,
  input  lkvt_pkg::cmd_t cmd_i,
  output lkvt_pkg::sts_t sts_o,
  output logic           done_o,
  output lkvt_pkg::rsp_t rsp_o
);
  import lkvt_pkg::*;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];

  req_t             req_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [VAL_W-1:0] hit_val_q, hit_val_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [COUNT_W-1:0] iss_q, iss_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               pend_q, pend_d;
  logic               hit_q, hit_d;
  logic               done_q;
  rsp_t               rsp_q, rsp_d;

  logic               cmp_hit, more, full;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  logic [KEY_W-1:0]   wr_key;
  logic [VAL_W-1:0]   wr_val;
  logic [COUNT_W-1:0] cnt_last;

  assign cmp_hit  = pend_q && (key_rd_q == req_q.key);
  assign more     = (iss_q < count_q);
  assign full     = (count_q == COUNT_W'(CAPACITY));
  assign cnt_last = count_q - COUNT_W'(1);

  assign sts_o.search_done = cmp_hit || !more;
  assign sts_o.del_hit     = cmp_hit && (req_q.operation == OP_DEL);

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Scan and result control
  always_comb begin
    iss_d       = iss_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    hit_val_d   = hit_val_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q[SLOT_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_key      = key_rd_q;
    wr_val      = val_rd_q;

    if (cmd_i.load) begin
      iss_d  = '0;
      pend_d = 1'b0;
      hit_d  = 1'b0;
    end

    if (cmd_i.search) begin
      if (cmp_hit) begin
        hit_d     = 1'b1;
        slot_d    = pend_slot_q;
        hit_val_d = val_rd_q;
        pend_d    = 1'b0;
      end else if (more) begin
        rd_en       = 1'b1;
        pend_d      = 1'b1;
        pend_slot_d = iss_q[SLOT_W-1:0];
        iss_d       = iss_q + COUNT_W'(1);
      end else begin
        hit_d  = 1'b0;
        pend_d = 1'b0;
      end
    end

    if (cmd_i.del_read) begin
      rd_en   = 1'b1;
      rd_addr = cnt_last[SLOT_W-1:0];
    end

    if (cmd_i.del_write) begin
      // Move the last entry into the freed slot.
      wr_en   = 1'b1;
      wr_addr = slot_q;
      count_d = cnt_last;
      rsp_d.found       = 1'b1;
      rsp_d.value_out   = '0;
      rsp_d.status      = ST_OK;
      rsp_d.entry_count = CNT_OUT_W'(cnt_last);
    end

    if (cmd_i.finish) begin
      rsp_d.found     = 1'b0;
      rsp_d.value_out = '0;
      rsp_d.status    = ST_OK;
      if (req_q.operation == OP_GET) begin
        rsp_d.found = hit_q;
        if (hit_q) begin
          rsp_d.value_out = hit_val_q;
        end
      end else if (req_q.operation == OP_SET) begin
        wr_val = req_q.value_in;
        wr_key = req_q.key;
        if (hit_q) begin
          rsp_d.found = 1'b1;
          wr_en       = 1'b1;
          wr_addr     = slot_q;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = count_q[SLOT_W-1:0];
          count_d = count_q + COUNT_W'(1);
        end
      end
      rsp_d.entry_count = CNT_OUT_W'(count_d);
    end
  end

  // Entry memories: one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
      val_rd_q <= val_mem[rd_addr];
    end
    if (wr_en) begin
      val_mem[wr_addr] <= wr_val;
      // A set that updates a present key keeps the stored key.
      if (!(cmd_i.finish && hit_q)) begin
        key_mem[wr_addr] <= wr_key;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    slot_q      <= slot_d;
    hit_val_q   <= hit_val_d;
    rsp_q       <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      hit_q   <= hit_d;
      count_q <= count_d;
      done_q  <= cmd_i.finish || cmd_i.del_write;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: src/linear_key_value_table.sv
// Top level of the linear key-value table: controller plus datapath.
//
// Usage: raise start with a request on req_i (operation, key, value_in)
// while busy is low; the transaction is taken at that clock edge and busy
// rises in the next cycle. Operations are get, set (update or append) and
// delete (the last entry is moved into the freed slot). Any other code is
// a no-op that still reports the count.
// Exactly one result per request appears on rsp_o, flagged by done_o
// for a single cycle. The receiver cannot stall: sample it in that cycle.
// Scan: the scan reads one stored entry per cycle through the single
// read port of the entry memory and compares it in the next cycle. It
// stops at the first hit or after the last stored entry; a delete hit
// adds a step that reads the last entry and moves it into the freed slot.
// busy is already low in the cycle done_o is shown, so the next request
// may be accepted at the edge that ends the result cycle.
// Reset (rst_ni low, asynchronous) empties the table: the count returns
// to zero and no result is pending. No clearing pass is needed since only
// slots below the count are ever read.
module linear_key_value_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lkvt_pkg::req_t req_i,
  output logic           done_o,
  output lkvt_pkg::rsp_t rsp_o
);
  import lkvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each transaction: load, scan, then finish or move the last entry.
  lkvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Hold the entries, the count and the registered result.
  lkvt_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// File: src/lkvt_checker.sv
// Port-level checker for the linear key-value table and its bind.
module lkvt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input lkvt_pkg::rsp_t rsp_o
);
  import lkvt_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.entry_count <= CNT_OUT_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_FULL)) |->
      (!rsp_o.found && (rsp_o.entry_count == CNT_OUT_W'(CAPACITY))))
    else $error("refused set without a full table");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.found) |-> (rsp_o.value_out == '0))
    else $error("value returned on a miss");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (.*);
